[rtl/nat_masquerade_connection_table_unit_assert.svh]
// Assertion helpers for the masquerade connection table.
// The macros use the clk and rst_n names of the module that includes them.
`ifndef NAT_MASQUERADE_CONNECTION_TABLE_UNIT_ASSERT_SVH
`define NAT_MASQUERADE_CONNECTION_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NMCT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmct check failed");

// Next-cycle implication, checked outside reset.
`define NMCT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmct check failed");

`endif

[rtl/nmct_pkg.sv]
// ----------------------------------------------------------------------------
// nmct_pkg
// Shared types and constants of the masquerade connection table.
// ----------------------------------------------------------------------------
package nmct_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [15:0] NEXT_PORT_RESET  = 16'd61000;
    localparam logic [15:0] FREE_PORTS_RESET = 16'd4096;
    localparam logic [31:0] MASQ_ADDR_RESET  = 32'd0;
    localparam logic [15:0] PORT_BEGIN_RESET = 16'd61000;
    localparam logic [15:0] PORT_END_RESET   = 16'd65096;
    localparam logic [31:0] TCP_TO_RESET     = 32'd90000;
    localparam logic [31:0] TCP_FIN_TO_RESET = 32'd12000;
    localparam logic [31:0] UDP_TO_RESET     = 32'd30000;

    typedef enum logic [1:0] {
        CMD_OUT  = 2'd0,
        CMD_IN   = 2'd1,
        CMD_TICK = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_MATCH = 3'd1,
        ST_RANGE    = 3'd2,
        ST_UNSUP    = 3'd3,
        ST_FULL     = 3'd4,
        ST_TICK     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CFG_MASQ_ADDR   = 3'd0,
        CFG_PORT_BEGIN  = 3'd1,
        CFG_PORT_END    = 3'd2,
        CFG_TCP_TO      = 3'd3,
        CFG_TCP_FIN_TO  = 3'd4,
        CFG_UDP_TO      = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SCAN_OUT  = 2'd0,
        SCAN_IN   = 2'd1,
        SCAN_PORT = 2'd2,
        SCAN_TICK = 2'd3
    } scan_kind_t;

    typedef struct packed {
        logic any_remote;
        logic rst_seen;
        logic fin_in;
        logic fin_out;
    } flags_t;

    typedef struct packed {
        logic        is_tcp;
        logic [31:0] inner_addr;
        logic [15:0] inner_port;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [31:0] masq_addr;
        logic [15:0] masq_port;
        flags_t      flags;
        logic [31:0] time_left;
    } entry_t;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan_run;
        scan_kind_t kind;
        logic       tried_clr;
        logic       take_port;
        logic       commit_new;
        logic       update;
        logic       res_set;
        status_t    res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic is_bad;
        logic is_in;
        logic range_bad;
        logic hit;
        logic scan_done;
        logic fc_zero;
        logic no_free;
        logic tried_done;
        logic res_free;
    } dp_sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOOKUP,
        S_ALLOC,
        S_PORT_TAKE,
        S_PORT_SCAN,
        S_COMMIT,
        S_UPDATE,
        S_TICK,
        S_DONE
    } ctl_state_t;

endpackage

[rtl/nat_masquerade_connection_table_unit.sv]
// ----------------------------------------------------------------------------
// nat_masquerade_connection_table_unit
// Source-NAT connection table for UDP and TCP with port allocation and aging.
// ----------------------------------------------------------------------------
// One item is in work at a time. Every table pass reads the entry memory one
// entry per cycle through its single registered read port. A tick is one pass;
// an inbound packet or an outbound hit is one lookup pass; an outbound miss adds
// one further pass per masquerade port tried, so creating an entry takes two
// passes when the first port tried is free, and grows with each port that is
// already taken. Unsupported items and out-of-range inbound ports finish
// without a table pass.
// No clearing pass is needed after reset: entry valid bits clear at once.
module nat_masquerade_connection_table_unit
#(
    parameter int TABLE_ENTRIES = nmct_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input beat
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_addr,
    input  logic [15:0] src_port,
    input  logic [31:0] dst_addr,
    input  logic [15:0] dst_port,
    input  logic        tcp_fin,
    input  logic        tcp_rst,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // result beat
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] new_addr,
    output logic [15:0] new_port,
    output logic [5:0]  entry_index
);

    nmct_pkg::dp_cmd_t dp_cmd;
    nmct_pkg::dp_sts_t dp_sts;

    // Sequence the scans; hold off new beats while an item is in work.
    nmct_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // Table memory, allocator, timers and the result register.
    nmct_dp
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .sts         (dp_sts),
        .cmd_in      (cmd),
        .protocol    (protocol),
        .src_addr    (src_addr),
        .src_port    (src_port),
        .dst_addr    (dst_addr),
        .dst_port    (dst_port),
        .tcp_fin     (tcp_fin),
        .tcp_rst     (tcp_rst),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .new_addr    (new_addr),
        .new_port    (new_port),
        .entry_index (entry_index)
    );

    `include "nat_masquerade_connection_table_unit_assert.svh"

    // An accepted beat leaves the sequencer busy in the following cycle.
    `NMCT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
    // Only a translation carries address, port and index.
    `NMCT_ASSERT_NOW(a_zero_fields, out_valid && (status != nmct_pkg::ST_OK), new_addr == 32'd0 && new_port == 16'd0 && entry_index == 6'd0)
    // Commit and table write never collide with a running scan step.
    `NMCT_ASSERT_NOW(a_cmd_excl, dp_cmd.commit_new || dp_cmd.update, !dp_cmd.scan_run)

endmodule

[rtl/nmct_ctrl.sv]
// ----------------------------------------------------------------------------
// nmct_ctrl
// Sequencer: runs lookup, port allocation and aging scans over the datapath.
// ----------------------------------------------------------------------------
module nmct_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nmct_pkg::dp_sts_t sts,
    output nmct_pkg::dp_cmd_t cmd
);

    nmct_pkg::ctl_state_t state_reg, state_next;
    nmct_pkg::status_t    st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nmct_pkg::S_IDLE;
            st_reg    <= nmct_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd            = '0;
        cmd.res_status = st_reg;
        in_ready       = 1'b0;
        case (state_reg)
            nmct_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = nmct_pkg::S_DECODE;
                end
            end
            nmct_pkg::S_DECODE:
            begin
                cmd.scan_clr = 1'b1;
                if (sts.is_tick)
                    state_next = nmct_pkg::S_TICK;
                else if (sts.is_bad)
                begin
                    st_next    = nmct_pkg::ST_UNSUP;
                    state_next = nmct_pkg::S_DONE;
                end
                else if (sts.is_in && sts.range_bad)
                begin
                    st_next    = nmct_pkg::ST_RANGE;
                    state_next = nmct_pkg::S_DONE;
                end
                else
                    state_next = nmct_pkg::S_LOOKUP;
            end
            nmct_pkg::S_LOOKUP:
            begin
                cmd.scan_run = 1'b1;
                cmd.kind     = sts.is_in ? nmct_pkg::SCAN_IN : nmct_pkg::SCAN_OUT;
                if (sts.hit)
                    state_next = nmct_pkg::S_UPDATE;
                else if (sts.scan_done)
                begin
                    if (sts.is_in)
                    begin
                        st_next    = nmct_pkg::ST_NO_MATCH;
                        state_next = nmct_pkg::S_DONE;
                    end
                    else
                        state_next = nmct_pkg::S_ALLOC;
                end
            end
            nmct_pkg::S_ALLOC:
            begin
                cmd.tried_clr = 1'b1;
                if (sts.fc_zero || sts.no_free)
                begin
                    st_next    = nmct_pkg::ST_FULL;
                    state_next = nmct_pkg::S_DONE;
                end
                else
                    state_next = nmct_pkg::S_PORT_TAKE;
            end
            nmct_pkg::S_PORT_TAKE:
            begin
                if (sts.tried_done)
                begin
                    st_next    = nmct_pkg::ST_FULL;
                    state_next = nmct_pkg::S_DONE;
                end
                else
                begin
                    cmd.take_port = 1'b1;
                    cmd.scan_clr  = 1'b1;
                    state_next    = nmct_pkg::S_PORT_SCAN;
                end
            end
            nmct_pkg::S_PORT_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.kind     = nmct_pkg::SCAN_PORT;
                if (sts.hit)
                    state_next = nmct_pkg::S_PORT_TAKE;
                else if (sts.scan_done)
                    state_next = nmct_pkg::S_COMMIT;
            end
            nmct_pkg::S_COMMIT:
            begin
                cmd.commit_new = 1'b1;
                state_next     = nmct_pkg::S_UPDATE;
            end
            nmct_pkg::S_UPDATE:
            begin
                cmd.update = 1'b1;
                st_next    = nmct_pkg::ST_OK;
                state_next = nmct_pkg::S_DONE;
            end
            nmct_pkg::S_TICK:
            begin
                cmd.scan_run = 1'b1;
                cmd.kind     = nmct_pkg::SCAN_TICK;
                if (sts.scan_done)
                begin
                    st_next    = nmct_pkg::ST_TICK;
                    state_next = nmct_pkg::S_DONE;
                end
            end
            nmct_pkg::S_DONE:
            begin
                if (sts.res_free)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = nmct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nmct_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/nmct_dp.sv]
// ----------------------------------------------------------------------------
// nmct_dp
// Datapath: entry memory, valid bits, scan pipeline, port allocator, result.
// ----------------------------------------------------------------------------
module nmct_dp
#(
    parameter int TABLE_ENTRIES = nmct_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  nmct_pkg::dp_cmd_t cmd,
    output nmct_pkg::dp_sts_t sts,
    input  logic [1:0]        cmd_in,
    input  logic [7:0]        protocol,
    input  logic [31:0]       src_addr,
    input  logic [15:0]       src_port,
    input  logic [31:0]       dst_addr,
    input  logic [15:0]       dst_port,
    input  logic              tcp_fin,
    input  logic              tcp_rst,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [31:0]       new_addr,
    output logic [15:0]       new_port,
    output logic [5:0]        entry_index
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int EW = (AW > 6) ? AW : 6;
    localparam logic [AW:0] N_CNT = (AW + 1)'(TABLE_ENTRIES);

    // item
    nmct_pkg::cmd_t cmd_reg;
    logic [7:0]     proto_reg;
    logic [31:0]    sa_reg, da_reg;
    logic [15:0]    sp_reg, dp_reg;
    logic           fin_reg, rst_reg;

    // configuration
    logic [31:0] masq_addr_reg, tcp_to_reg, tcp_fin_to_reg, udp_to_reg;
    logic [15:0] port_begin_reg, port_end_reg;

    // table
    nmct_pkg::entry_t       mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // scan pipeline
    logic [AW:0]       cnt_reg;
    logic              rd_pend_reg;
    logic [AW-1:0]     rd_idx_reg;
    nmct_pkg::entry_t  rd_data_reg;

    logic              hit_reg;
    logic [AW-1:0]     hit_idx_reg;
    nmct_pkg::entry_t  hit_rec_reg;
    logic              ff_found_reg;
    logic [AW-1:0]     free_idx_reg;

    logic [15:0] next_port_reg, mport_reg, tried_reg;
    logic [15:0] free_udp_reg, free_tcp_reg;

    logic        res_valid_reg;
    logic [2:0]  res_status_reg;
    logic [31:0] res_addr_reg;
    logic [15:0] res_port_reg;
    logic [5:0]  res_idx_reg;

    logic             tcp, cur_valid, match, hit_now, rd_en;
    logic             tick_act, tick_expire;
    logic [15:0]      fc_sel, np_inc;
    nmct_pkg::flags_t upd_flags;
    logic [31:0]      upd_time;
    nmct_pkg::entry_t new_rec, upd_rec, tick_rec, wdata;
    logic             mem_we;
    logic [AW-1:0]    waddr;
    logic [EW-1:0]    idx_ext;

    assign tcp       = (proto_reg == nmct_pkg::PROTO_TCP);
    assign fc_sel    = tcp ? free_tcp_reg : free_udp_reg;
    assign cur_valid = rd_pend_reg && valid_reg[rd_idx_reg];
    assign rd_en     = cmd.scan_run && (cnt_reg < N_CNT);
    assign np_inc    = next_port_reg + 16'd1;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (cmd.kind)
            nmct_pkg::SCAN_OUT:
                match = (rd_data_reg.is_tcp == tcp) && (rd_data_reg.inner_addr == sa_reg)
                     && (rd_data_reg.inner_port == sp_reg)
                     && (rd_data_reg.remote_addr == da_reg)
                     && (rd_data_reg.remote_port == dp_reg);
            nmct_pkg::SCAN_IN:
                match = (rd_data_reg.is_tcp == tcp)
                     && ((rd_data_reg.remote_addr == sa_reg) || rd_data_reg.flags.any_remote)
                     && (rd_data_reg.remote_port == sp_reg)
                     && (rd_data_reg.masq_addr == da_reg)
                     && (rd_data_reg.masq_port == dp_reg);
            nmct_pkg::SCAN_PORT:
                match = (rd_data_reg.is_tcp == tcp)
                     && (rd_data_reg.masq_addr == masq_addr_reg)
                     && (rd_data_reg.masq_port == mport_reg);
            default:
                match = 1'b0;
        endcase
    end

    assign hit_now     = cmd.scan_run && cur_valid && match;
    assign tick_act    = cmd.scan_run && (cmd.kind == nmct_pkg::SCAN_TICK) && cur_valid
                      && (rd_data_reg.time_left != 32'd0);
    assign tick_expire = tick_act && (rd_data_reg.time_left == 32'd1);

    // new entry and timeout selection
    always_comb
    begin
        new_rec                  = '0;
        new_rec.is_tcp           = tcp;
        new_rec.inner_addr       = sa_reg;
        new_rec.inner_port       = sp_reg;
        new_rec.remote_addr      = da_reg;
        new_rec.remote_port      = dp_reg;
        new_rec.masq_addr        = masq_addr_reg;
        new_rec.masq_port        = mport_reg;
        new_rec.flags.any_remote = !tcp;

        upd_flags = hit_rec_reg.flags;
        if (tcp)
        begin
            if (fin_reg)
            begin
                if (cmd_reg == nmct_pkg::CMD_IN)
                    upd_flags.fin_in = 1'b1;
                else
                    upd_flags.fin_out = 1'b1;
            end
            if (rst_reg)
                upd_flags.rst_seen = 1'b1;
        end
        if (!tcp)
            upd_time = udp_to_reg;
        else if (upd_flags.rst_seen)
            upd_time = 32'd1;
        else if (upd_flags.fin_in && upd_flags.fin_out)
            upd_time = tcp_fin_to_reg;
        else
            upd_time = tcp_to_reg;

        upd_rec           = hit_rec_reg;
        upd_rec.flags     = upd_flags;
        upd_rec.time_left = upd_time;

        tick_rec           = rd_data_reg;
        tick_rec.time_left = rd_data_reg.time_left - 32'd1;

        mem_we = cmd.update || tick_act;
        waddr  = cmd.update ? hit_idx_reg : rd_idx_reg;
        wdata  = cmd.update ? upd_rec : tick_rec;
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (rd_en)
            rd_data_reg <= mem[cnt_reg[AW-1:0]];
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= nmct_pkg::cmd_t'(cmd_in);
            proto_reg <= protocol;
            sa_reg    <= src_addr;
            sp_reg    <= src_port;
            da_reg    <= dst_addr;
            dp_reg    <= dst_port;
            fin_reg   <= tcp_fin;
            rst_reg   <= tcp_rst;
        end
        if (cmd.take_port)
            mport_reg <= next_port_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masq_addr_reg  <= nmct_pkg::MASQ_ADDR_RESET;
            port_begin_reg <= nmct_pkg::PORT_BEGIN_RESET;
            port_end_reg   <= nmct_pkg::PORT_END_RESET;
            tcp_to_reg     <= nmct_pkg::TCP_TO_RESET;
            tcp_fin_to_reg <= nmct_pkg::TCP_FIN_TO_RESET;
            udp_to_reg     <= nmct_pkg::UDP_TO_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                nmct_pkg::CFG_MASQ_ADDR:  masq_addr_reg  <= cfg_data;
                nmct_pkg::CFG_PORT_BEGIN: port_begin_reg <= cfg_data[15:0];
                nmct_pkg::CFG_PORT_END:   port_end_reg   <= cfg_data[15:0];
                nmct_pkg::CFG_TCP_TO:     tcp_to_reg     <= cfg_data;
                nmct_pkg::CFG_TCP_FIN_TO: tcp_fin_to_reg <= cfg_data;
                nmct_pkg::CFG_UDP_TO:     udp_to_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // scan, allocation and bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            ff_found_reg  <= 1'b0;
            free_idx_reg  <= '0;
            valid_reg     <= '0;
            next_port_reg <= nmct_pkg::NEXT_PORT_RESET;
            tried_reg     <= '0;
            free_udp_reg  <= nmct_pkg::FREE_PORTS_RESET;
            free_tcp_reg  <= nmct_pkg::FREE_PORTS_RESET;
        end
        else
        begin
            if (cmd.load)
                ff_found_reg <= 1'b0;
            if (cmd.scan_clr)
            begin
                cnt_reg     <= '0;
                rd_pend_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                if (rd_en)
                begin
                    cnt_reg     <= cnt_reg + 1'b1;
                    rd_pend_reg <= 1'b1;
                    rd_idx_reg  <= cnt_reg[AW-1:0];
                end
                else
                    rd_pend_reg <= 1'b0;
                if (hit_now && !hit_reg && (cmd.kind != nmct_pkg::SCAN_TICK))
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                    hit_rec_reg <= rd_data_reg;
                end
                // remember the lowest free slot while looking up outbound
                if ((cmd.kind == nmct_pkg::SCAN_OUT) && rd_pend_reg
                    && !valid_reg[rd_idx_reg] && !ff_found_reg)
                begin
                    ff_found_reg <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end
            if (tick_expire)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
                if (rd_data_reg.is_tcp)
                    free_tcp_reg <= free_tcp_reg + 16'd1;
                else
                    free_udp_reg <= free_udp_reg + 16'd1;
            end
            if (cmd.tried_clr)
                tried_reg <= '0;
            if (cmd.take_port)
            begin
                tried_reg     <= tried_reg + 16'd1;
                next_port_reg <= (np_inc == port_end_reg) ? port_begin_reg : np_inc;
            end
            if (cmd.commit_new)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                hit_idx_reg             <= free_idx_reg;
                hit_rec_reg             <= new_rec;
                if (tcp)
                    free_tcp_reg <= free_tcp_reg - 16'd1;
                else
                    free_udp_reg <= free_udp_reg - 16'd1;
            end
        end
    end

    // result register
    assign idx_ext = EW'(hit_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.res_set)
            res_valid_reg <= 1'b1;
        else if (out_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            if (cmd.res_status == nmct_pkg::ST_OK)
            begin
                res_addr_reg <= (cmd_reg == nmct_pkg::CMD_IN) ? hit_rec_reg.inner_addr
                                                              : hit_rec_reg.masq_addr;
                res_port_reg <= (cmd_reg == nmct_pkg::CMD_IN) ? hit_rec_reg.inner_port
                                                              : hit_rec_reg.masq_port;
                res_idx_reg  <= idx_ext[5:0];
            end
            else
            begin
                res_addr_reg <= '0;
                res_port_reg <= '0;
                res_idx_reg  <= '0;
            end
        end
    end

    assign out_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign new_addr    = res_addr_reg;
    assign new_port    = res_port_reg;
    assign entry_index = res_idx_reg;

    always_comb
    begin
        sts            = '0;
        sts.is_tick    = (cmd_reg == nmct_pkg::CMD_TICK);
        sts.is_bad     = (cmd_reg == nmct_pkg::CMD_RSVD)
                      || ((proto_reg != nmct_pkg::PROTO_TCP) && (proto_reg != nmct_pkg::PROTO_UDP));
        sts.is_in      = (cmd_reg == nmct_pkg::CMD_IN);
        sts.range_bad  = (dp_reg < port_begin_reg) || (dp_reg > port_end_reg);
        sts.hit        = hit_reg;
        sts.scan_done  = (cnt_reg == N_CNT) && !rd_pend_reg;
        sts.fc_zero    = (fc_sel == 16'd0);
        sts.no_free    = !ff_found_reg;
        sts.tried_done = (tried_reg >= fc_sel);
        sts.res_free   = !res_valid_reg || out_ready;
    end

endmodule

[verif/nat_masquerade_connection_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_masquerade_connection_table_checker
// Tracks the translation table beside the unit and checks every result beat.
// ----------------------------------------------------------------------------
// Watches the config, input and result channels. Config beats update local
// registers; input beats update a local copy of the table and queue the
// expected result beat. Each result beat is compared with the oldest queued one.
module nat_masquerade_connection_table_checker
    import nmct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_addr,
    input  logic [15:0] src_port,
    input  logic [31:0] dst_addr,
    input  logic [15:0] dst_port,
    input  logic        tcp_fin,
    input  logic        tcp_rst,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [31:0] new_addr,
    input  logic [15:0] new_port,
    input  logic [5:0]  entry_index,
    output int          fail_count,
    output int          pending
);
    localparam int N = TABLE_ENTRIES_DEF;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] addr;
        logic [15:0] port;
        logic [5:0]  idx;
    } xlate_t;

    xlate_t want_q[$];

    logic [31:0] r_masq, r_tcp_to, r_fin_to, r_udp_to;
    logic [15:0] r_begin, r_end;

    logic        t_vld[N];
    logic        t_tcp[N];
    logic [31:0] t_iaddr[N], t_raddr[N], t_maddr[N], t_left[N];
    logic [15:0] t_iport[N], t_rport[N], t_mport[N];
    logic [3:0]  t_flg[N];  // bit0 any remote, bit1 fin out, bit2 fin in, bit3 rst
    logic [15:0] nxt_port, free_udp, free_tcp;

    function automatic logic port_busy(logic tcp, logic [31:0] ma, logic [15:0] mp);
        for (int i = 0; i < N; i++)
            if (t_vld[i] && t_tcp[i] == tcp && t_maddr[i] == ma && t_mport[i] == mp)
                return 1'b1;
        return 1'b0;
    endfunction

    // refresh the idle timer, folding in FIN/RST bits for TCP
    function automatic void touch(int e, logic tcp, logic [3:0] fbit, logic fin, logic rst);
        if (!tcp)
        begin
            t_left[e] = r_udp_to;
            return;
        end
        if (fin) t_flg[e] |= fbit;
        if (rst) t_flg[e] |= 4'b1000;
        if (t_flg[e][3]) t_left[e] = 32'd1;
        else if (t_flg[e][2:1] == 2'b11) t_left[e] = r_fin_to;
        else t_left[e] = r_tcp_to;
    endfunction

    function automatic int open_entry(logic tcp, logic [31:0] sa, logic [15:0] sp,
                                      logic [31:0] da, logic [15:0] dp);
        int e;
        logic [15:0] fc, mp;
        e = -1;
        fc = tcp ? free_tcp : free_udp;
        if (fc == 0) return -1;
        for (int i = 0; i < N; i++)
            if (!t_vld[i])
            begin
                e = i;
                break;
            end
        if (e < 0) return -1;
        for (int k = 0; k < fc; k++)
        begin
            mp = nxt_port;
            nxt_port = nxt_port + 16'd1;
            if (nxt_port == r_end) nxt_port = r_begin;
            if (!port_busy(tcp, r_masq, mp))
            begin
                if (tcp) free_tcp = free_tcp - 1;
                else free_udp = free_udp - 1;
                t_vld[e] = 1'b1;
                t_tcp[e] = tcp;
                t_iaddr[e] = sa;
                t_iport[e] = sp;
                t_raddr[e] = da;
                t_rport[e] = dp;
                t_mport[e] = mp;
                t_maddr[e] = r_masq;
                t_flg[e] = tcp ? 4'b0000 : 4'b0001;
                t_left[e] = 0;
                return e;
            end
        end
        return -1;
    endfunction

    function automatic xlate_t translate(logic [1:0] c, logic [7:0] pr, logic [31:0] sa,
                                         logic [15:0] sp, logic [31:0] da,
                                         logic [15:0] dp, logic fin, logic rst);
        xlate_t r;
        logic tcp;
        int e;
        r = '0;
        e = -1;
        tcp = (pr == PROTO_TCP);
        if (c == CMD_TICK)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (!t_vld[i] || t_left[i] == 0) continue;
                t_left[i] = t_left[i] - 1;
                if (t_left[i] == 0)
                begin
                    t_vld[i] = 1'b0;
                    if (t_tcp[i]) free_tcp = free_tcp + 1;
                    else free_udp = free_udp + 1;
                end
            end
            r.st = ST_TICK;
            return r;
        end
        if (c == CMD_RSVD || (pr != PROTO_TCP && pr != PROTO_UDP))
        begin
            r.st = ST_UNSUP;
            return r;
        end
        if (c == CMD_OUT)
        begin
            for (int i = 0; i < N; i++)
                if (t_vld[i] && t_tcp[i] == tcp && t_iaddr[i] == sa && t_iport[i] == sp
                    && t_raddr[i] == da && t_rport[i] == dp)
                begin
                    e = i;
                    break;
                end
            if (e < 0) e = open_entry(tcp, sa, sp, da, dp);
            if (e < 0)
            begin
                r.st = ST_FULL;
                return r;
            end
            touch(e, tcp, 4'b0010, fin, rst);
            r.addr = t_maddr[e];
            r.port = t_mport[e];
        end
        else
        begin
            if (dp < r_begin || dp > r_end)
            begin
                r.st = ST_RANGE;
                return r;
            end
            for (int i = 0; i < N; i++)
                if (t_vld[i] && t_tcp[i] == tcp && (t_raddr[i] == sa || t_flg[i][0])
                    && t_rport[i] == sp && t_maddr[i] == da && t_mport[i] == dp)
                begin
                    e = i;
                    break;
                end
            if (e < 0)
            begin
                r.st = ST_NO_MATCH;
                return r;
            end
            touch(e, tcp, 4'b0100, fin, rst);
            r.addr = t_iaddr[e];
            r.port = t_iport[e];
        end
        r.st = ST_OK;
        r.idx = e[5:0];
        return r;
    endfunction

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        xlate_t got, exp_r;
        if (!rst_n)
        begin
            r_masq = MASQ_ADDR_RESET;
            r_begin = PORT_BEGIN_RESET;
            r_end = PORT_END_RESET;
            r_tcp_to = TCP_TO_RESET;
            r_fin_to = TCP_FIN_TO_RESET;
            r_udp_to = UDP_TO_RESET;
            for (int i = 0; i < N; i++)
            begin
                t_vld[i] = 1'b0;
                t_tcp[i] = 1'b0;
                t_iaddr[i] = 0; t_raddr[i] = 0; t_maddr[i] = 0; t_left[i] = 0;
                t_iport[i] = 0; t_rport[i] = 0; t_mport[i] = 0; t_flg[i] = 0;
            end
            nxt_port = NEXT_PORT_RESET;
            free_udp = FREE_PORTS_RESET;
            free_tcp = FREE_PORTS_RESET;
            want_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MASQ_ADDR:  r_masq = cfg_data;
                    CFG_PORT_BEGIN: r_begin = cfg_data[15:0];
                    CFG_PORT_END:   r_end = cfg_data[15:0];
                    CFG_TCP_TO:     r_tcp_to = cfg_data;
                    CFG_TCP_FIN_TO: r_fin_to = cfg_data;
                    CFG_UDP_TO:     r_udp_to = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                want_q.push_back(translate(cmd, protocol, src_addr, src_port, dst_addr,
                                           dst_port, tcp_fin, tcp_rst));
            if (out_valid && out_ready)
            begin
                got = '{status, new_addr, new_port, entry_index};
                if (want_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    exp_r = want_q.pop_front();
                    if (got.st !== exp_r.st)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.st, got.st);
                        fail_count++;
                    end
                    if (got.addr !== exp_r.addr)
                    begin
                        $display("%0t: new_addr exp %h got %h", $time, exp_r.addr, got.addr);
                        fail_count++;
                    end
                    if (got.port !== exp_r.port)
                    begin
                        $display("%0t: new_port exp %0d got %0d", $time, exp_r.port, got.port);
                        fail_count++;
                    end
                    if (got.idx !== exp_r.idx)
                    begin
                        $display("%0t: entry_index exp %0d got %0d", $time, exp_r.idx, got.idx);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

[verif/nat_masquerade_connection_table_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_masquerade_connection_table_unit_tb
// Drives packets, ticks and register writes into the masquerade table.
// ----------------------------------------------------------------------------
// Directed beats cover every command, protocol class, range edge and flag
// combination; random phases then replay small flow sets (outbound opens,
// inbound replies, ticks) under several register settings. The checker
// beside the unit predicts and compares every result beat.
module nat_masquerade_connection_table_unit_tb;
    import nmct_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic        tcp_fin;
    logic        tcp_rst;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] new_addr;
    logic [15:0] new_port;
    logic [5:0]  entry_index;
    int          fail_count;
    int          pending;

    // current register view, used to aim inbound beats at live masq ports
    logic [31:0] cur_masq;
    logic [15:0] cur_begin, cur_end;

    // flow pool: inner/remote endpoints that outbound and inbound beats reuse
    logic [31:0] pool_in_addr[8], pool_rem_addr[8];
    logic [15:0] pool_in_port[8], pool_rem_port[8];
    logic [15:0] seen_port[$];

    nat_masquerade_connection_table_unit uut (.*);

    nat_masquerade_connection_table_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stall the result side at random, with calm stretches
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            repeat (wait_n) @(posedge clk) out_ready <= 1'b0;
            @(posedge clk) out_ready <= 1'b1;
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    task automatic send_beat(logic [1:0] c, logic [7:0] pr, logic [31:0] sa,
                             logic [15:0] sp, logic [31:0] da, logic [15:0] dp,
                             logic fin, logic rst);
        int gap;
        gap = $urandom_range(0, 5);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        protocol <= pr;
        src_addr <= sa;
        src_port <= sp;
        dst_addr <= da;
        dst_port <= dp;
        tcp_fin <= fin;
        tcp_rst <= rst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        in_valid <= 1'b0;
    endtask

    // hold until every result is back, then let the unit settle
    task automatic drain();
        int guard;
        guard = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MASQ_ADDR:  cur_masq = val;
            CFG_PORT_BEGIN: cur_begin = val[15:0];
            CFG_PORT_END:   cur_end = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_proto();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return PROTO_TCP;
        if (r < 8) return PROTO_UDP;
        return 8'($urandom);
    endfunction

    task automatic fill_pool();
        for (int i = 0; i < 8; i++)
        begin
            pool_in_addr[i] = $urandom;
            pool_rem_addr[i] = $urandom;
            pool_in_port[i] = $urandom;
            pool_rem_port[i] = $urandom;
        end
    endtask

    task automatic random_beat();
        int r, f, g;
        logic [15:0] mp;
        r = $urandom_range(0, 99);
        f = $urandom_range(0, 7);
        g = $urandom_range(0, 7);
        if (seen_port.size() > 0) mp = seen_port[$urandom_range(0, seen_port.size() - 1)];
        else mp = cur_begin;
        if (r < 40)
            send_beat(CMD_OUT, pick_proto(), pool_in_addr[f], pool_in_port[f],
                      pool_rem_addr[g], pool_rem_port[g],
                      $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
        else if (r < 70)
            // mostly proper replies; sometimes a wrong remote address
            send_beat(CMD_IN, pick_proto(),
                      ($urandom_range(0, 3) == 0) ? $urandom : pool_rem_addr[g],
                      pool_rem_port[g], cur_masq,
                      ($urandom_range(0, 5) == 0) ? cur_begin + 16'($urandom_range(0, 8)) : mp,
                      $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
        else if (r < 88)
            send_beat(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        else
            send_beat(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
    endtask

    // track masq ports handed out so inbound beats can hit them
    always @(posedge clk)
        if (out_valid && out_ready && status == ST_OK && new_addr == cur_masq
            && seen_port.size() < 64)
            seen_port.push_back(new_port);

    initial
    begin
        in_valid = 1'b0;
        cmd = CMD_OUT;
        protocol = 0;
        src_addr = 0;
        src_port = 0;
        dst_addr = 0;
        dst_port = 0;
        tcp_fin = 0;
        tcp_rst = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MASQ_ADDR;
        cfg_data = 0;
        cur_masq = MASQ_ADDR_RESET;
        cur_begin = PORT_BEGIN_RESET;
        cur_end = PORT_END_RESET;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, all commands, extremes, flag cases
        send_beat(CMD_OUT, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1);
        send_beat(CMD_OUT, PROTO_TCP, 32'h0, 16'h0, 32'h0, 16'h0, 0, 0);
        send_beat(CMD_IN, PROTO_UDP, 32'h1234_5678, 16'hFFFF, 32'h0, 16'd61000, 0, 0);
        send_beat(CMD_IN, PROTO_TCP, 32'h0, 16'h0, 32'h0, 16'd61001, 1, 0);
        send_beat(CMD_IN, PROTO_TCP, 32'h0, 16'h0, 32'h0, 16'd61001, 0, 0);
        send_beat(CMD_OUT, PROTO_TCP, 32'h0, 16'h0, 32'h0, 16'h0, 1, 0);
        send_beat(CMD_IN, PROTO_TCP, 32'h1, 16'h0, 32'h0, 16'd61001, 0, 0);
        send_beat(CMD_IN, PROTO_UDP, 32'h0, 16'h0, 32'h0, 16'd60999, 0, 0);
        send_beat(CMD_IN, PROTO_UDP, 32'h0, 16'h0, 32'h0, 16'd65096, 0, 0);
        send_beat(CMD_IN, PROTO_UDP, 32'h0, 16'h0, 32'h0, 16'd65097, 0, 0);
        send_beat(CMD_OUT, 8'd1, 32'h0, 16'h0, 32'h0, 16'h0, 0, 0);
        send_beat(CMD_IN, 8'hFF, 32'h0, 16'h0, 32'h0, 16'd61000, 0, 0);
        send_beat(CMD_RSVD, PROTO_TCP, 32'h0, 16'h0, 32'h0, 16'h0, 0, 0);
        send_beat(CMD_TICK, 8'h0, 32'h0, 16'h0, 32'h0, 16'h0, 0, 0);
        send_beat(CMD_OUT, PROTO_TCP, 32'hA, 16'd5, 32'hB, 16'd6, 0, 1);
        send_beat(CMD_TICK, 8'h0, 32'h0, 16'h0, 32'h0, 16'h0, 0, 0);
        send_beat(CMD_OUT, PROTO_TCP, 32'hA, 16'd5, 32'hB, 16'd6, 0, 0);
        drain();

        // tiny range, zero and one tick timeouts, full table; upside-down range
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [15:0] b;
            int          n;
            case (ph)
                0: begin write_reg(CFG_MASQ_ADDR, 32'hFFFF_FFFF); write_reg(CFG_PORT_BEGIN, 16'd1);
                         write_reg(CFG_PORT_END, 16'd4); write_reg(CFG_TCP_TO, 32'd0);
                         write_reg(CFG_TCP_FIN_TO, 32'd0); write_reg(CFG_UDP_TO, 32'd0); end
                1: begin write_reg(CFG_PORT_BEGIN, 16'd100); write_reg(CFG_PORT_END, 16'd200);
                         write_reg(CFG_TCP_TO, 32'd1); write_reg(CFG_TCP_FIN_TO, 32'd1);
                         write_reg(CFG_UDP_TO, 32'd1); end
                2: begin write_reg(CFG_PORT_BEGIN, 16'd65535); write_reg(CFG_PORT_END, 16'd2);
                         write_reg(CFG_UDP_TO, 32'hFFFF_FFFF); write_reg(CFG_TCP_TO, 32'hFFFF_FFFF); end
                default: begin
                    b = 16'($urandom_range(1, 65000));
                    write_reg(CFG_MASQ_ADDR, $urandom);
                    write_reg(CFG_PORT_BEGIN, b);
                    write_reg(CFG_PORT_END, b + 16'($urandom_range(1, 40)));
                    write_reg(CFG_TCP_TO, $urandom_range(1, 12));
                    write_reg(CFG_TCP_FIN_TO, $urandom_range(1, 6));
                    write_reg(CFG_UDP_TO, $urandom_range(1, 10));
                end
            endcase
            seen_port.delete();
            fill_pool();
            n = (ph < 3) ? 100 : 150;
            for (int k = 0; k < n; k++)
            begin
                // fresh endpoints now and then so the table fills up
                if ($urandom_range(0, 9) == 0)
                begin
                    int s;
                    s = $urandom_range(0, 7);
                    pool_in_addr[s] = $urandom;
                    pool_in_port[s] = $urandom;
                end
                random_beat();
            end
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/nmct_pkg.sv
rtl/nmct_ctrl.sv
rtl/nmct_dp.sv
rtl/nat_masquerade_connection_table_unit.sv
verif/nat_masquerade_connection_table_checker.sv
verif/nat_masquerade_connection_table_unit_tb.sv
